// ===== rtl/core/blrc_pkg.sv =====
// shared types and constants of the loss-recovery window controller
`default_nettype none

package blrc_pkg;

   localparam int unsigned WINDOW_W      = 32;
   localparam int unsigned SEGMENT_W     = 16;
   localparam int unsigned ACTION_W      = 2;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned CSR_DATA_W    = 32;

   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SEGMENT_W-1:0] SEGMENT_SIZE_RESET = 16'd1460;
   localparam logic [WINDOW_W-1:0]  WINDOW_LIMIT_RESET = 32'hFFFF_FFFF;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // event codes as they arrive on the request channel
   typedef enum logic [ACTION_W-1:0] {
      ACT_ENTER = 2'd0,
      ACT_ACK   = 2'd1,
      ACT_EXIT  = 2'd2
   } action_type;

   // classified operation handed to the back end
   typedef enum logic [1:0] {
      OP_ENTER  = 2'd0,
      OP_ACK    = 2'd1,
      OP_EXIT   = 2'd2,
      OP_REJECT = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SEGMENT_SIZE = 1'd0,
      REG_WINDOW_LIMIT = 1'd1
   } csr_reg_type;

   // one queue entry: everything that does not depend on recovery state
   typedef struct packed {
      op_type                op;
      logic                  window_ok;
      logic                  exit_ok;
      logic                  round_begins;
      logic [WINDOW_W-1:0]   current_window;
      logic [WINDOW_W-1:0]   cons_window;
      logic [WINDOW_W-1:0]   sub_window;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/blrc_if.sv =====
// channel interfaces: request, response and register write
`default_nettype none

interface blrc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] current_window;
   logic [31:0] inflight;
   logic [31:0] newly_acked;
   logic [31:0] newly_lost;
   logic        round_begins;

   modport source (output valid, action, current_window, inflight, newly_acked,
                   newly_lost, round_begins, input ready);
   modport sink   (input valid, action, current_window, inflight, newly_acked,
                   newly_lost, round_begins, output ready);
endinterface

interface blrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] new_window;
   logic        owns_window;

   modport source (output valid, status, new_window, owns_window, input ready);
   modport sink   (input valid, status, new_window, owns_window, output ready);
endinterface

interface blrc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/blrc_queue.sv =====
// short job queue between the classifier and the execution stage
`default_nettype none

module blrc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire blrc_pkg::job_type job_in,
   input  wire logic              pop,
   output blrc_pkg::job_type      job_out,
   output logic                   empty,
   output logic                   full
);
   import blrc_pkg::*;

   job_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign job_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/blrc_front.sv =====
// front end: takes request transactions and works out the state-free arithmetic
`default_nettype none

module blrc_front (
   blrc_req_if.sink                        req,
   input  wire logic [blrc_pkg::SEGMENT_W-1:0] segment_size,
   input  wire logic [blrc_pkg::WINDOW_W-1:0]  window_limit,
   input  wire logic                       queue_full,
   output logic                            push,
   output blrc_pkg::job_type               job
);
   import blrc_pkg::*;

   logic [WINDOW_W-1:0] mss;
   logic [WINDOW_W:0]   sum_wide;
   logic [WINDOW_W-1:0] sum_capped;
   logic [WINDOW_W-1:0] diff;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      mss        = WINDOW_W'(segment_size);
      sum_wide   = {1'b0, req.inflight} + {1'b0, req.newly_acked};
      sum_capped = (sum_wide > {1'b0, window_limit}) ? window_limit
                                                     : sum_wide[WINDOW_W-1:0];
      diff       = req.current_window - req.newly_lost;

      unique case (action_type'(req.action))
         ACT_ENTER: job.op = OP_ENTER;
         ACT_ACK:   job.op = OP_ACK;
         ACT_EXIT:  job.op = OP_EXIT;
         default:   job.op = OP_REJECT;
      endcase

      job.window_ok      = (mss != '0) && (window_limit >= mss) &&
                           (req.current_window >= mss) &&
                           (req.current_window <= window_limit);
      job.exit_ok        = (req.current_window != '0) && (window_limit != '0) &&
                           (req.current_window <= window_limit);
      job.round_begins   = req.round_begins;
      job.current_window = req.current_window;
      // inflight plus acked, saturated at the limit, floored at one segment
      job.cons_window    = (sum_capped < mss) ? mss : sum_capped;
      // losses off the window, never below one segment
      job.sub_window     = ((req.current_window <= req.newly_lost) || (diff < mss))
                           ? mss : diff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/blrc_back.sv =====
// back end: recovery state, per-event decision and the response register
`default_nettype none

module blrc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire blrc_pkg::job_type             job,
   input  wire logic                          queue_empty,
   input  wire logic [blrc_pkg::WINDOW_W-1:0] window_limit,
   output logic                               pop,
   blrc_rsp_if.source                         rsp
);
   import blrc_pkg::*;

   logic                recovering_ff, recovering_in;
   logic                conserving_ff, conserving_in;
   logic [WINDOW_W-1:0] saved_window_ff, saved_window_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [WINDOW_W-1:0] rsp_window_ff, rsp_window_in;
   logic                rsp_owns_ff, rsp_owns_in;

   logic                exec_ok;
   logic                exec_owns;
   logic [WINDOW_W-1:0] exec_win;
   logic                next_rec, next_cons;
   logic [WINDOW_W-1:0] next_saved;
   logic                keep_cons;
   logic [WINDOW_W-1:0] ack_win;
   logic [WINDOW_W-1:0] exit_max;

   assign pop = !queue_empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      keep_cons = conserving_ff && !job.round_begins;
      ack_win   = (keep_cons && (job.sub_window < job.cons_window)) ? job.cons_window
                                                                    : job.sub_window;
      exit_max  = (job.current_window > saved_window_ff) ? job.current_window
                                                         : saved_window_ff;
      exec_ok    = 1'b0;
      exec_owns  = 1'b0;
      exec_win   = '0;
      next_rec   = recovering_ff;
      next_cons  = conserving_ff;
      next_saved = saved_window_ff;

      unique case (job.op)
         OP_ENTER: begin
            exec_ok    = !recovering_ff && job.window_ok;
            exec_win   = job.cons_window;
            next_rec   = 1'b1;
            next_cons  = 1'b1;
            next_saved = job.current_window;
         end
         OP_ACK: begin
            exec_ok   = recovering_ff && job.window_ok;
            exec_owns = keep_cons;
            exec_win  = (ack_win > window_limit) ? window_limit : ack_win;
            next_cons = keep_cons;
         end
         OP_EXIT: begin
            exec_ok   = recovering_ff && job.exit_ok && (saved_window_ff != '0);
            exec_win  = (exit_max > window_limit) ? window_limit : exit_max;
            next_rec  = 1'b0;
            next_cons = 1'b0;
         end
         default: begin
            exec_ok = 1'b0;
         end
      endcase

      recovering_in   = recovering_ff;
      conserving_in   = conserving_ff;
      saved_window_in = saved_window_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_window_in   = rsp_window_ff;
      rsp_owns_in     = rsp_owns_ff;
      if (pop) begin
         if (exec_ok) begin
            recovering_in   = next_rec;
            conserving_in   = next_cons;
            saved_window_in = next_saved;
         end
         rsp_status_in = exec_ok ? STATUS_OK : STATUS_REJECT;
         rsp_window_in = exec_ok ? exec_win : '0;
         rsp_owns_in   = exec_ok && exec_owns;
      end
      rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recovering_ff   <= 1'b0;
         conserving_ff   <= 1'b0;
         saved_window_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         recovering_ff   <= recovering_in;
         conserving_ff   <= conserving_in;
         saved_window_ff <= saved_window_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_window_ff <= rsp_window_in;
      rsp_owns_ff   <= rsp_owns_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.new_window  = rsp_window_ff;
   assign rsp.owns_window = rsp_owns_ff;

`ifndef SYNTHESIS
   // conservation only ever runs inside recovery
   a_cons_in_recovery: assert property (@(posedge clock) disable iff (reset)
      conserving_ff |-> recovering_ff)
      else $error("conservation flag set outside recovery");

   // a rejected event leaves the recovery state alone
   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      (pop && !exec_ok) |=> (recovering_ff == $past(recovering_ff)) &&
                            (conserving_ff == $past(conserving_ff)) &&
                            (saved_window_ff == $past(saved_window_ff)))
      else $error("rejected event changed recovery state");

   // ownership is only reported on an accepted event while still in recovery
   a_owns_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_owns_ff) |-> (rsp_status_ff == STATUS_OK) && recovering_ff)
      else $error("window ownership on a rejected event or outside recovery");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bbr_loss_recovery_cwnd.sv =====
// top level of the loss-recovery congestion-window controller
// usage:
//   req_ch carries one event per transaction: enter recovery, ack or exit
//   recovery, with the current window, inflight, acked and lost byte counts
//   rsp_ch returns exactly one result per event: status, new window and a
//   flag that says whether packet conservation set the window
//   csr_ch writes segment_size (index 0) and window_limit (index 1); it is
//   always ready; the user must write it only while no event is outstanding (the block does not enforce this)
// timing:
//   the front end classifies an event in the cycle it is taken and drops it
//   into a two-entry queue; the back end pops it from the queue and executes
//   it into the response register, so a result passes a queue entry and the
//   response register before it shows on rsp_ch
//   one event per cycle is sustained while rsp_ch is ready; the recovery
//   state registers in the back end are read and updated once per cycle
// reset:
//   recovery and conservation flags and the saved window clear, segment_size
//   returns to 1460 and window_limit to all ones, the queue empties
// back-pressure:
//   while rsp_ch is stalled the response register holds, the queue fills up
//   to its two entries and then req_ch ready drops
`default_nettype none

module bbr_loss_recovery_cwnd (
   input  wire logic  clock,
   input  wire logic  reset,
   blrc_req_if.sink   req_ch,
   blrc_rsp_if.source rsp_ch,
   blrc_csr_if.sink   csr_ch
);
   import blrc_pkg::*;

   logic [SEGMENT_W-1:0] segment_size_ff, segment_size_in;
   logic [WINDOW_W-1:0]  window_limit_ff, window_limit_in;

   job_type front_job;
   job_type queue_job;
   logic    front_push;
   logic    queue_pop;
   logic    queue_empty;
   logic    queue_full;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      segment_size_in = segment_size_ff;
      window_limit_in = window_limit_ff;
      if (csr_ch.valid) begin
         unique case (csr_reg_type'(csr_ch.index))
            REG_SEGMENT_SIZE: segment_size_in = csr_ch.data[SEGMENT_W-1:0];
            REG_WINDOW_LIMIT: window_limit_in = csr_ch.data[WINDOW_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_size_ff <= SEGMENT_SIZE_RESET;
         window_limit_ff <= WINDOW_LIMIT_RESET;
      end else begin
         segment_size_ff <= segment_size_in;
         window_limit_ff <= window_limit_in;
      end
   end

   // classification and state-free arithmetic
   blrc_front u_front (
      .req          (req_ch),
      .segment_size (segment_size_ff),
      .window_limit (window_limit_ff),
      .queue_full   (queue_full),
      .push         (front_push),
      .job          (front_job)
   );

   // decouples request acceptance from execution
   blrc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .job_in  (front_job),
      .pop     (queue_pop),
      .job_out (queue_job),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   // recovery state and response register
   blrc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job          (queue_job),
      .queue_empty  (queue_empty),
      .window_limit (window_limit_ff),
      .pop          (queue_pop),
      .rsp          (rsp_ch)
   );

endmodule

`default_nettype wire
